>>> rtl/core/cail_pkg.sv
// Shared types and constants for the common-ancestor info lookup block.
// Used by cail_ctrl, cail_datapath and the top level; depends on nothing.
`default_nettype none

package cail_pkg;

   localparam int OP_W    = 2;
   localparam int TERM_W  = 10;
   localparam int RANGE_W = 15;
   localparam int SLOT_W  = 14;
   localparam int ANC_W   = 10;
   localparam int LOAD_W  = 32;
   localparam int SIM_W   = 32;

   typedef enum logic [OP_W-1:0] {
      OP_RANGE = 2'd0,
      OP_SLOT  = 2'd1,
      OP_INFO  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANGE_RD,
      ST_RANGE_CHK,
      ST_FETCH,
      ST_COMPARE,
      ST_HIT,
      ST_RESULT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // item taken this cycle: capture terms, do load writes
      logic load_walk;  // set up both list pointers, clear the pending answer
      logic step_a;     // advance the first list
      logic step_b;     // advance the second list
      logic set_hit;    // latch the common ancestor's info
      logic load_out;   // move the answer into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic query_ok;   // both terms valid and both lists non-empty
      logic adv_b;      // second list entry is smaller and not at its end
      logic match;      // entries agree
      logic last_a;     // first list pointer sits on its last entry
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/core/cail_ctrl.sv
// Sequencer for the lookup block: handshakes, query walk control, output valid.
// Depends on cail_pkg for state, command and status types.
`default_nettype none

module cail_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cail_pkg::op_type req_op,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire cail_pkg::sts_type sts,
   output cail_pkg::cmd_type     cmd
);
   import cail_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_op == OP_QUERY) state_in = ST_RANGE_RD;
         end
         ST_RANGE_RD:  state_in = ST_RANGE_CHK;
         ST_RANGE_CHK: state_in = sts.query_ok ? ST_FETCH : ST_RESULT;
         ST_FETCH:     state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (sts.adv_b)       state_in = ST_FETCH;
            else if (sts.match)  state_in = ST_HIT;
            else if (sts.last_a) state_in = ST_RESULT;
            else                 state_in = ST_FETCH;
         end
         ST_HIT:    state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:      cmd.accept    = req_valid;
         ST_RANGE_CHK: cmd.load_walk = 1'b1;
         ST_COMPARE: begin
            if (sts.adv_b)
               cmd.step_b = 1'b1;
            else if (!sts.match && !sts.last_a)
               cmd.step_a = 1'b1;
         end
         ST_HIT:       cmd.set_hit   = 1'b1;
         ST_RESULT:    cmd.load_out  = out_free;
         default:      cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/cail_datapath.sv
// Datapath: range, ancestor and info memories, list pointers, result registers.
// Depends on cail_pkg; driven by cail_ctrl through cmd_type / sts_type.
`default_nettype none

module cail_datapath #(
   parameter int TERM_COUNT     = 1024,
   parameter int ANCESTOR_SLOTS = 16384,
   parameter int INFO_BITS      = 32
) (
   input  wire logic                          clock,
   input  wire cail_pkg::cmd_type             cmd,
   output cail_pkg::sts_type                  sts,
   input  wire logic [cail_pkg::OP_W-1:0]     req_operation,
   input  wire logic [cail_pkg::TERM_W-1:0]   req_term_a,
   input  wire logic [cail_pkg::TERM_W-1:0]   req_term_b,
   input  wire logic [cail_pkg::RANGE_W-1:0]  req_range_start,
   input  wire logic [cail_pkg::RANGE_W-1:0]  req_range_stop,
   input  wire logic [cail_pkg::SLOT_W-1:0]   req_slot_index,
   input  wire logic [cail_pkg::ANC_W-1:0]    req_ancestor_term,
   input  wire logic [cail_pkg::LOAD_W-1:0]   req_info_value,
   output logic [cail_pkg::SIM_W-1:0]         rsp_similarity,
   output logic                               rsp_found
);
   import cail_pkg::*;

   localparam int TERM_AW = $clog2(TERM_COUNT);
   localparam int SLOT_AW = $clog2(ANCESTOR_SLOTS);
   localparam int SPAN_W  = $clog2(ANCESTOR_SLOTS + 1);
   localparam int PTR_W   = (SPAN_W > RANGE_W) ? SPAN_W : RANGE_W;

   logic [2*RANGE_W-1:0] range_mem [TERM_COUNT];
   logic [ANC_W-1:0]     anc_mem   [ANCESTOR_SLOTS];
   logic [INFO_BITS-1:0] info_mem  [TERM_COUNT];

   logic [TERM_W-1:0]    ta_ff, tb_ff;
   logic [2*RANGE_W-1:0] rng_a_rd_ff, rng_b_rd_ff;
   logic [ANC_W-1:0]     anc_a_rd_ff, anc_b_rd_ff;
   logic [INFO_BITS-1:0] info_rd_ff;
   logic [PTR_W-1:0]     i_ff, i_in, e1_ff, e1_in, cur_ff, cur_in, last_ff, last_in;
   logic [SIM_W-1:0]     res_sim_ff, res_sim_in, sim_out_ff;
   logic                 res_found_ff, res_found_in, found_out_ff;

   op_type               op;
   logic                 wr_ta_ok, wr_slot_ok, ta_ok, tb_ok, anc_ok;
   logic [PTR_W-1:0]     s1, s2, stop1, stop2, e1, e2, slots_w;

   assign op         = op_type'(req_operation);
   assign wr_ta_ok   = 32'(req_term_a) < 32'(TERM_COUNT);
   assign wr_slot_ok = 32'(req_slot_index) < 32'(ANCESTOR_SLOTS);

   // load writes happen at acceptance
   always_ff @(posedge clock) begin
      if (cmd.accept && op == OP_RANGE && wr_ta_ok)
         range_mem[TERM_AW'(req_term_a)] <= {req_range_start, req_range_stop};
      if (cmd.accept && op == OP_SLOT && wr_slot_ok)
         anc_mem[SLOT_AW'(req_slot_index)] <= ANC_W'(req_ancestor_term);
      if (cmd.accept && op == OP_INFO && wr_ta_ok)
         info_mem[TERM_AW'(req_term_a)] <= INFO_BITS'(req_info_value);
   end

   // registered reads every cycle, addressed from the held terms, the list pointers and the first ancestor read
   always_ff @(posedge clock) begin
      rng_a_rd_ff <= range_mem[TERM_AW'(ta_ff)];
      rng_b_rd_ff <= range_mem[TERM_AW'(tb_ff)];
      anc_a_rd_ff <= anc_mem[i_ff[SLOT_AW-1:0]];
      anc_b_rd_ff <= anc_mem[cur_ff[SLOT_AW-1:0]];
      info_rd_ff  <= info_mem[TERM_AW'(anc_a_rd_ff)];
   end

   // list bounds, stop saturated to the store size
   always_comb begin
      slots_w = PTR_W'(ANCESTOR_SLOTS);
      s1      = PTR_W'(rng_a_rd_ff[2*RANGE_W-1:RANGE_W]);
      stop1   = PTR_W'(rng_a_rd_ff[RANGE_W-1:0]);
      s2      = PTR_W'(rng_b_rd_ff[2*RANGE_W-1:RANGE_W]);
      stop2   = PTR_W'(rng_b_rd_ff[RANGE_W-1:0]);
      e1      = (stop1 > slots_w) ? slots_w : stop1;
      e2      = (stop2 > slots_w) ? slots_w : stop2;
   end

   assign ta_ok  = 32'(ta_ff) < 32'(TERM_COUNT);
   assign tb_ok  = 32'(tb_ff) < 32'(TERM_COUNT);
   assign anc_ok = 32'(anc_a_rd_ff) < 32'(TERM_COUNT);

   always_comb begin
      sts.query_ok = ta_ok && tb_ok && (s1 < e1) && (s2 < e2);
      sts.adv_b    = (cur_ff < last_ff) && (anc_b_rd_ff < anc_a_rd_ff);
      sts.match    = (anc_b_rd_ff == anc_a_rd_ff);
      sts.last_a   = (i_ff + PTR_W'(1)) >= e1_ff;
   end

   always_comb begin
      i_in         = i_ff;
      e1_in        = e1_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      res_sim_in   = res_sim_ff;
      res_found_in = res_found_ff;
      if (cmd.load_walk) begin
         i_in         = s1;
         e1_in        = e1;
         cur_in       = s2;
         last_in      = e2 - PTR_W'(1);
         res_sim_in   = '0;
         res_found_in = 1'b0;
      end
      if (cmd.step_a) i_in   = i_ff + PTR_W'(1);
      if (cmd.step_b) cur_in = cur_ff + PTR_W'(1);
      if (cmd.set_hit) begin
         res_found_in = 1'b1;
         res_sim_in   = anc_ok ? SIM_W'(info_rd_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ta_ff <= req_term_a;
         tb_ff <= req_term_b;
      end
      i_ff         <= i_in;
      e1_ff        <= e1_in;
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      res_sim_ff   <= res_sim_in;
      res_found_ff <= res_found_in;
      if (cmd.load_out) begin
         sim_out_ff   <= res_sim_ff;
         found_out_ff <= res_found_ff;
      end
   end

   assign rsp_similarity = sim_out_ff;
   assign rsp_found      = found_out_ff;

endmodule

`default_nettype wire

>>> rtl/core/common_ancestor_info_lookup.sv
// Load items (range, ancestor slot, info) are written at acceptance and
// give no result. A query passes through acceptance, range read, range
// check and loading the answer, with a fetch and a compare step for each
// comparison of the merge walk (one per advance of either ancestor list,
// plus the final one), and an info fetch step on a hit; a query with an
// empty list or an invalid term goes from the range check straight to
// loading the answer. The registered read of the ancestor store is why
// each comparison needs its own fetch step. The result sits in an output
// register, so load items keep flowing while a query answer waits to be taken.
// Top level: instantiates cail_ctrl and cail_datapath; depends on cail_pkg.
`default_nettype none

module common_ancestor_info_lookup #(
   parameter int TERM_COUNT     = 1024,
   parameter int ANCESTOR_SLOTS = 16384,
   parameter int INFO_BITS      = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [cail_pkg::OP_W-1:0]     req_operation,
   input  wire logic [cail_pkg::TERM_W-1:0]   req_term_a,
   input  wire logic [cail_pkg::TERM_W-1:0]   req_term_b,
   input  wire logic [cail_pkg::RANGE_W-1:0]  req_range_start,
   input  wire logic [cail_pkg::RANGE_W-1:0]  req_range_stop,
   input  wire logic [cail_pkg::SLOT_W-1:0]   req_slot_index,
   input  wire logic [cail_pkg::ANC_W-1:0]    req_ancestor_term,
   input  wire logic [cail_pkg::LOAD_W-1:0]   req_info_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [cail_pkg::SIM_W-1:0]         rsp_similarity,
   output logic                               rsp_found
);
   import cail_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cail_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (op_type'(req_operation)),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cail_datapath #(
      .TERM_COUNT     (TERM_COUNT),
      .ANCESTOR_SLOTS (ANCESTOR_SLOTS),
      .INFO_BITS      (INFO_BITS)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_term_a        (req_term_a),
      .req_term_b        (req_term_b),
      .req_range_start   (req_range_start),
      .req_range_stop    (req_range_stop),
      .req_slot_index    (req_slot_index),
      .req_ancestor_term (req_ancestor_term),
      .req_info_value    (req_info_value),
      .rsp_similarity    (rsp_similarity),
      .rsp_found         (rsp_found)
   );

`ifndef SYNTH
   // a miss always reports zero
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_similarity == '0)
      else $error("miss reported with nonzero similarity");

   // a query holds off further input for at least the range read
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_QUERY |=> !req_ready)
      else $error("input taken during query setup");

   // never overwrite an answer that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid || rsp_ready)
      else $error("output register overwritten");
`endif

endmodule

`default_nettype wire
